FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; they compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

FILE: design/nwlt_pkg.sv
// ----------------------------------------------------------------------------
// nwlt_pkg
// Shared types and codes of the no-wait lock table.
// ----------------------------------------------------------------------------
`default_nettype none
package nwlt_pkg;

    // Default table geometry
    localparam int LOCK_ENTRIES_DEF = 64;
    localparam int HOLDERS_DEF      = 8;

    // Fixed field widths
    localparam int KEY_W = 59;
    localparam int TXN_W = 8;
    localparam int ST_W  = 3;

    // Request code bits
    localparam int REQ_EXCL_BIT   = 0;
    localparam int REQ_UNLOCK_BIT = 1;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK             = 3'd0;
    localparam logic [ST_W-1:0] ST_ABORT_SHRINK   = 3'd1;
    localparam logic [ST_W-1:0] ST_ABORT_DEADLOCK = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND      = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL           = 3'd4;

    // One granted holder
    typedef struct packed {
        logic             excl;
        logic [TXN_W-1:0] txn;
    } t_holder;

endpackage
`default_nettype wire

FILE: design/nwlt_if.sv
// ----------------------------------------------------------------------------
// nwlt_req_if / nwlt_rsp_if
// Valid/ready channels for lock requests and their results.
// ----------------------------------------------------------------------------
`default_nettype none
interface nwlt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic        has_txn;
    logic [7:0]  txn_id;
    logic        txn_shrinking;
    logic        is_record;
    logic [9:0]  table_id;
    logic [31:0] record_page;
    logic [15:0] record_slot;

    modport source (output valid, req_type, has_txn, txn_id, txn_shrinking,
                    is_record, table_id, record_page, record_slot,
                    input ready);
    modport sink   (input valid, req_type, has_txn, txn_id, txn_shrinking,
                    is_record, table_id, record_page, record_slot,
                    output ready);
endinterface

interface nwlt_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       add_to_lock_set;
    logic       remove_from_lock_set;
    logic       enter_shrinking;

    modport source (output valid, status, add_to_lock_set, remove_from_lock_set,
                    enter_shrinking, input ready);
    modport sink   (input valid, status, add_to_lock_set, remove_from_lock_set,
                    enter_shrinking, output ready);
endinterface
`default_nettype wire

FILE: design/no_wait_lock_table_top.sv
// ----------------------------------------------------------------------------
// no_wait_lock_table_top
// No-wait two-phase lock table: entry search, holder scan and holder shift
// under one sequencer with single-read-port key, count and holder memories.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  i_req    in   valid/ready    req_type has_txn txn_id txn_shrinking key fields
//  o_rsp    out  valid/ready    status add/remove lock set enter_shrinking
//
//  Steps: a request without transaction, or a lock by a shrinking transaction,
//  goes straight to the result. Otherwise the key search reads and compares the
//  entries in turn (all LOCK_ENTRIES on a miss); a hit reads the holder count,
//  scans the holders (up to HOLDERS) and, on an unlock, moves each later holder
//  down one place. Each memory has a single read port.
//  Reset: valid bits clear at once; no clearing pass.
//  Stalls: a finished result waits in the output register; a new request is
//  taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module no_wait_lock_table_top import nwlt_pkg::*; #(
    parameter int LOCK_ENTRIES = LOCK_ENTRIES_DEF,
    parameter int HOLDERS      = HOLDERS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    nwlt_req_if.sink    i_req,
    nwlt_rsp_if.source  o_rsp
);

    localparam int EW = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
    localparam int CW = $clog2(HOLDERS + 1);
    localparam int AW = (LOCK_ENTRIES * HOLDERS > 1) ? $clog2(LOCK_ENTRIES * HOLDERS) : 1;
    localparam logic [EW-1:0] LAST_ENT = EW'(LOCK_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_ERD, S_ECMP, S_CRD, S_HRD, S_HCMP, S_SHRD, S_SHWR, S_DONE
    } t_state;

    // Memories
    logic [KEY_W-1:0] key_mem [LOCK_ENTRIES];
    logic [CW-1:0]    cnt_mem [LOCK_ENTRIES];
    t_holder          hold_mem[LOCK_ENTRIES * HOLDERS];
    logic [KEY_W-1:0] r_key_q;
    logic [CW-1:0]    r_cnt_q;
    t_holder          r_hold_q;

    // Sequencer registers
    t_state                  r_state, n_state;
    logic [LOCK_ENTRIES-1:0] r_entry_valid, n_entry_valid;
    logic [KEY_W-1:0]        r_key, n_key;
    logic [TXN_W-1:0]        r_txn, n_txn;
    logic                    r_want_x, n_want_x;
    logic                    r_unlock, n_unlock;
    logic                    r_shr, n_shr;
    logic [EW-1:0]           r_addr, n_addr;
    logic [EW-1:0]           r_ent, n_ent;
    logic [EW-1:0]           r_free, n_free;
    logic                    r_free_ok, n_free_ok;
    logic [AW-1:0]           r_base, n_base;
    logic [CW-1:0]           r_h, n_h;
    logic [ST_W-1:0]         r_res_st, n_res_st;
    logic                    r_res_add, n_res_add;
    logic                    r_res_rem, n_res_rem;
    logic                    r_res_shr, n_res_shr;
    logic                    r_ov, n_ov;
    logic [ST_W-1:0]         r_o_st, n_o_st;
    logic                    r_o_add, n_o_add;
    logic                    r_o_rem, n_o_rem;
    logic                    r_o_shr, n_o_shr;

    // Memory write ports
    logic             key_we;
    logic [EW-1:0]    key_waddr;
    logic             cnt_we;
    logic [EW-1:0]    cnt_waddr;
    logic [CW-1:0]    cnt_wdata;
    logic             hold_we;
    logic [AW-1:0]    hold_waddr;
    t_holder          hold_wdata;

    logic             acc;
    logic             ent_v;
    logic             free_hit;
    logic [EW-1:0]    free_idx;
    logic [AW-1:0]    hold_raddr;

    assign acc        = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign hold_raddr = r_base + AW'(r_h);
    assign ent_v      = r_entry_valid[r_addr];
    assign free_hit   = r_free_ok || !ent_v;
    assign free_idx   = r_free_ok ? r_free : r_addr;

    // Read and write the key, count and holder memories
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[key_waddr] <= r_key;
        end
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (hold_we) begin
            hold_mem[hold_waddr] <= hold_wdata;
        end
        r_key_q  <= key_mem[r_addr];
        r_cnt_q  <= cnt_mem[r_ent];
        r_hold_q <= hold_mem[hold_raddr];
    end

    // Next-state logic of the sequencer
    always_comb begin
        n_state       = r_state;
        n_entry_valid = r_entry_valid;
        n_key         = r_key;
        n_txn         = r_txn;
        n_want_x      = r_want_x;
        n_unlock      = r_unlock;
        n_shr         = r_shr;
        n_addr        = r_addr;
        n_ent         = r_ent;
        n_free        = r_free;
        n_free_ok     = r_free_ok;
        n_base        = r_base;
        n_h           = r_h;
        n_res_st      = r_res_st;
        n_res_add     = r_res_add;
        n_res_rem     = r_res_rem;
        n_res_shr     = r_res_shr;
        n_ov          = r_ov && !o_rsp.ready;
        n_o_st        = r_o_st;
        n_o_add       = r_o_add;
        n_o_rem       = r_o_rem;
        n_o_shr       = r_o_shr;
        key_we        = 1'b0;
        key_waddr     = r_ent;
        cnt_we        = 1'b0;
        cnt_waddr     = r_ent;
        cnt_wdata     = r_cnt_q;
        hold_we       = 1'b0;
        hold_waddr    = hold_raddr;
        hold_wdata    = '{excl: r_want_x, txn: r_txn};

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    // Capture the request and build the key
                    n_key     = {i_req.is_record, i_req.table_id,
                                 i_req.is_record ? i_req.record_page : 32'd0,
                                 i_req.is_record ? i_req.record_slot : 16'd0};
                    n_txn     = i_req.txn_id;
                    n_want_x  = i_req.req_type[REQ_EXCL_BIT];
                    n_unlock  = i_req.req_type[REQ_UNLOCK_BIT];
                    n_shr     = i_req.txn_shrinking;
                    n_addr    = '0;
                    n_free_ok = 1'b0;
                    n_res_st  = ST_OK;
                    n_res_add = 1'b0;
                    n_res_rem = 1'b0;
                    n_res_shr = 1'b0;
                    if (!i_req.has_txn) begin
                        n_state = S_DONE;
                    end else if (!i_req.req_type[REQ_UNLOCK_BIT] && i_req.txn_shrinking) begin
                        n_res_st = ST_ABORT_SHRINK;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_ERD;
                    end
                end
            end
            S_ERD: begin
                n_state = S_ECMP;
            end
            S_ECMP: begin
                if (ent_v && r_key_q == r_key) begin
                    // Hit: fetch the holder count
                    n_ent   = r_addr;
                    n_state = S_CRD;
                end else begin
                    n_free    = free_idx;
                    n_free_ok = free_hit;
                    if (r_addr == LAST_ENT) begin
                        if (r_unlock) begin
                            n_res_st = ST_NOT_FOUND;
                        end else if (free_hit) begin
                            // Allocate the entry with this transaction as sole holder
                            n_entry_valid[free_idx] = 1'b1;
                            key_we     = 1'b1;
                            key_waddr  = free_idx;
                            cnt_we     = 1'b1;
                            cnt_waddr  = free_idx;
                            cnt_wdata  = CW'(1);
                            hold_we    = 1'b1;
                            hold_waddr = AW'(free_idx) * AW'(HOLDERS);
                            n_res_add  = 1'b1;
                        end else begin
                            n_res_st = ST_FULL;
                        end
                        n_state = S_DONE;
                    end else begin
                        n_addr  = r_addr + EW'(1);
                        n_state = S_ERD;
                    end
                end
            end
            S_CRD: begin
                n_base  = AW'(r_ent) * AW'(HOLDERS);
                n_h     = '0;
                n_state = S_HRD;
            end
            S_HRD: begin
                if (r_h == r_cnt_q) begin
                    // End of holder list without a match
                    if (r_unlock) begin
                        if (r_cnt_q == '0) begin
                            n_entry_valid[r_ent] = 1'b0;
                        end
                        n_res_rem = 1'b1;
                        n_res_shr = !r_shr;
                    end else if (r_cnt_q >= CW'(HOLDERS)) begin
                        n_res_st = ST_FULL;
                    end else begin
                        hold_we   = 1'b1;
                        cnt_we    = 1'b1;
                        cnt_wdata = r_cnt_q + CW'(1);
                        n_res_add = 1'b1;
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_HCMP;
                end
            end
            S_HCMP: begin
                if (r_hold_q.txn == r_txn) begin
                    if (r_unlock) begin
                        // Close the gap behind the removed holder
                        n_h     = r_h + CW'(1);
                        n_state = S_SHRD;
                    end else begin
                        if (r_hold_q.excl || r_hold_q.excl == r_want_x) begin
                            n_res_st = ST_OK;
                        end else if (r_cnt_q > CW'(1)) begin
                            n_res_st = ST_ABORT_DEADLOCK;
                        end else begin
                            hold_we   = 1'b1;
                            n_res_add = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                end else if (!r_unlock && (r_hold_q.excl || r_want_x)) begin
                    n_res_st = ST_ABORT_DEADLOCK;
                    n_state  = S_DONE;
                end else begin
                    n_h     = r_h + CW'(1);
                    n_state = S_HRD;
                end
            end
            S_SHRD: begin
                if (r_h == r_cnt_q) begin
                    // Drop one holder and free the entry once empty
                    cnt_we    = 1'b1;
                    cnt_wdata = r_cnt_q - CW'(1);
                    if (r_cnt_q == CW'(1)) begin
                        n_entry_valid[r_ent] = 1'b0;
                    end
                    n_res_rem = 1'b1;
                    n_res_shr = !r_shr;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                hold_we    = 1'b1;
                hold_waddr = hold_raddr - AW'(1);
                hold_wdata = r_hold_q;
                n_h        = r_h + CW'(1);
                n_state    = S_SHRD;
            end
            S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov    = 1'b1;
                    n_o_st  = r_res_st;
                    n_o_add = r_res_add;
                    n_o_rem = r_res_rem;
                    n_o_shr = r_res_shr;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_valid <= '0;
            r_ov          <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_entry_valid <= n_entry_valid;
            r_ov          <= n_ov;
        end
        r_key     <= n_key;
        r_txn     <= n_txn;
        r_want_x  <= n_want_x;
        r_unlock  <= n_unlock;
        r_shr     <= n_shr;
        r_addr    <= n_addr;
        r_ent     <= n_ent;
        r_free    <= n_free;
        r_free_ok <= n_free_ok;
        r_base    <= n_base;
        r_h       <= n_h;
        r_res_st  <= n_res_st;
        r_res_add <= n_res_add;
        r_res_rem <= n_res_rem;
        r_res_shr <= n_res_shr;
        r_o_st    <= n_o_st;
        r_o_add   <= n_o_add;
        r_o_rem   <= n_o_rem;
        r_o_shr   <= n_o_shr;
    end

    assign o_rsp.valid                = r_ov;
    assign o_rsp.status               = r_o_st;
    assign o_rsp.add_to_lock_set      = r_o_add;
    assign o_rsp.remove_from_lock_set = r_o_rem;
    assign o_rsp.enter_shrinking      = r_o_shr;

    // Checks
    `ASSERT_PROP(a_alloc_valid, i_clk, i_rst_n, key_we |=> r_entry_valid[$past(key_waddr)], "allocated entry not valid")
    `ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, (r_state == S_HCMP) && (r_cnt_q > CW'(HOLDERS)), "holder count overflow")
    `ASSERT_PROP(a_load_done, i_clk, i_rst_n, ($rose(r_ov) |-> $past(r_state) == S_DONE), "result loaded outside done")
    `ASSERT_PROP(a_no_txn, i_clk, i_rst_n, (acc && !i_req.has_txn) |=> (r_state == S_DONE && r_res_st == ST_OK), "no-transaction request not answered at once")
    `ASSERT_NEVER(a_lock_flags, i_clk, i_rst_n, r_ov && r_o_add && r_o_rem, "add and remove both set")

endmodule
`default_nettype wire

FILE: tb/no_wait_lock_table_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// no_wait_lock_table_top_test
// Drives lock and unlock requests into the no-wait lock table and checks
// each result against a behavioral lock table kept in a scoreboard class.
// Covers grants, upgrades, conflicts, shrinking aborts, full table and full
// holder lists, with random stalls on both channels.
// ----------------------------------------------------------------------------
module no_wait_lock_table_top_test;
    import nwlt_pkg::*;

    localparam int NUM_ENTRIES = 64;
    localparam int NUM_HOLDERS = 8;
    localparam int RANDOM_ITEMS = 1750;
    localparam int QUIET_TAIL = 200;
    localparam int IDLE_LIMIT = 5000;

    // Request codes
    localparam logic [1:0] REQ_SHARED     = 2'd0;
    localparam logic [1:0] REQ_EXCLUSIVE  = 2'd1;
    localparam logic [1:0] REQ_UNLOCK     = 2'd2;
    localparam logic [1:0] REQ_UNLOCK_ALT = 2'd3;

    typedef struct {
        logic [1:0]  req_type;
        logic        has_txn;
        logic [7:0]  txn_id;
        logic        txn_shrinking;
        logic        is_record;
        logic [9:0]  table_id;
        logic [31:0] record_page;
        logic [15:0] record_slot;
    } lock_request_t;

    typedef struct {
        logic [ST_W-1:0] status;
        logic            add;
        logic            remove;
        logic            shrink;
    } lock_result_t;

    // Lock table shadow plus the queue of results still owed by the block
    class lock_table_scoreboard;
        bit               used[NUM_ENTRIES];
        logic [KEY_W-1:0] key_of[NUM_ENTRIES];
        int               n_holders[NUM_ENTRIES];
        logic [TXN_W-1:0] holder_id[NUM_ENTRIES][NUM_HOLDERS];
        bit               holder_x[NUM_ENTRIES][NUM_HOLDERS];
        lock_result_t     owed_results[$];
        int               errors;
        int               checked;
        int               status_seen[5];

        function lock_result_t mk(logic [ST_W-1:0] st, bit a, bit r, bit s);
            lock_result_t res;
            res.status = st; res.add = a; res.remove = r; res.shrink = s;
            return res;
        endfunction

        function int find_key(logic [KEY_W-1:0] k);
            for (int e = 0; e < NUM_ENTRIES; e++)
                if (used[e] && key_of[e] == k) return e;
            return -1;
        endfunction

        // Apply one request to the shadow table and return its result
        function lock_result_t grant_or_release(lock_request_t r);
            logic [KEY_W-1:0] k;
            int e;
            int n;
            bit want_x;
            k = {r.is_record, r.table_id,
                 r.is_record ? r.record_page : 32'd0,
                 r.is_record ? r.record_slot : 16'd0};
            want_x = r.req_type[REQ_EXCL_BIT];
            if (!r.has_txn) return mk(ST_OK, 1'b0, 1'b0, 1'b0);
            e = find_key(k);
            if (r.req_type[REQ_UNLOCK_BIT]) begin
                if (e < 0) return mk(ST_NOT_FOUND, 1'b0, 1'b0, 1'b0);
                n = n_holders[e];
                for (int h = 0; h < n; h++) begin
                    if (holder_id[e][h] == r.txn_id) begin
                        for (int j = h; j + 1 < n; j++) begin
                            holder_id[e][j] = holder_id[e][j+1];
                            holder_x[e][j] = holder_x[e][j+1];
                        end
                        n--;
                        break;
                    end
                end
                n_holders[e] = n;
                if (n == 0) used[e] = 0;
                return mk(ST_OK, 1'b0, 1'b1, !r.txn_shrinking);
            end
            if (r.txn_shrinking) return mk(ST_ABORT_SHRINK, 1'b0, 1'b0, 1'b0);
            if (e < 0) begin
                for (int f = 0; f < NUM_ENTRIES; f++)
                    if (!used[f]) begin e = f; break; end
                if (e < 0) return mk(ST_FULL, 1'b0, 1'b0, 1'b0);
                used[e] = 1; key_of[e] = k; n_holders[e] = 0;
            end
            n = n_holders[e];
            for (int h = 0; h < n; h++) begin
                if (holder_id[e][h] == r.txn_id) begin
                    if (holder_x[e][h] || holder_x[e][h] == want_x)
                        return mk(ST_OK, 1'b0, 1'b0, 1'b0);
                    if (n > 1) return mk(ST_ABORT_DEADLOCK, 1'b0, 1'b0, 1'b0);
                    holder_x[e][h] = want_x;
                    return mk(ST_OK, 1'b1, 1'b0, 1'b0);
                end
                if (holder_x[e][h] || want_x)
                    return mk(ST_ABORT_DEADLOCK, 1'b0, 1'b0, 1'b0);
            end
            if (n >= NUM_HOLDERS) return mk(ST_FULL, 1'b0, 1'b0, 1'b0);
            holder_id[e][n] = r.txn_id;
            holder_x[e][n] = want_x;
            n_holders[e] = n + 1;
            return mk(ST_OK, 1'b1, 1'b0, 1'b0);
        endfunction

        function void note_request(lock_request_t r);
            owed_results.push_back(grant_or_release(r));
        endfunction

        task report(string what, logic [7:0] got, logic [7:0] want);
            $display("%0t mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(lock_result_t got);
            lock_result_t want;
            if (owed_results.size() == 0) begin
                report("results outstanding", 8'd1, 8'd0);
                return;
            end
            want = owed_results.pop_front();
            checked++;
            if (want.status < 5) status_seen[want.status]++;
            if (got.status !== want.status)
                report("status", 8'(got.status), 8'(want.status));
            if (got.add !== want.add)
                report("add_to_lock_set", 8'(got.add), 8'(want.add));
            if (got.remove !== want.remove)
                report("remove_from_lock_set", 8'(got.remove), 8'(want.remove));
            if (got.shrink !== want.shrink)
                report("enter_shrinking", 8'(got.shrink), 8'(want.shrink));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   quiet;
    int   sent;
    int   idle_cycles;
    int   ready_gap;

    nwlt_req_if req_ch ();
    nwlt_rsp_if rsp_ch ();
    lock_table_scoreboard sb = new();

    no_wait_lock_table_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Clock
    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // Stall the result channel in random bursts
    always @(negedge i_clk) begin
        if (ready_gap > 0) begin
            ready_gap--;
            rsp_ch.ready = 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            ready_gap = $urandom_range(0, 5);
            rsp_ch.ready = 1'b0;
        end else begin
            rsp_ch.ready = 1'b1;
        end
    end

    // Check results and watch for a hung block
    always @(posedge i_clk) begin
        lock_result_t got;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.status = rsp_ch.status;
                got.add = rsp_ch.add_to_lock_set;
                got.remove = rsp_ch.remove_from_lock_set;
                got.shrink = rsp_ch.enter_shrinking;
                sb.check_result(got);
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Drive one request until accepted; leaves time at the next falling edge
    task automatic send_req(lock_request_t r);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.req_type = r.req_type;
        req_ch.has_txn = r.has_txn;
        req_ch.txn_id = r.txn_id;
        req_ch.txn_shrinking = r.txn_shrinking;
        req_ch.is_record = r.is_record;
        req_ch.table_id = r.table_id;
        req_ch.record_page = r.record_page;
        req_ch.record_slot = r.record_slot;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(r);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic lock_request_t mk_req(logic [1:0] op, logic [7:0] txn, bit shr,
                                             bit rec, logic [9:0] tbl,
                                             logic [31:0] page, logic [15:0] slot);
        lock_request_t r;
        r.req_type = op; r.has_txn = 1'b1; r.txn_id = txn; r.txn_shrinking = shr;
        r.is_record = rec; r.table_id = tbl; r.record_page = page; r.record_slot = slot;
        return r;
    endfunction

    function automatic lock_request_t req_for_key(logic [1:0] op, logic [7:0] txn, bit shr,
                                                  logic [KEY_W-1:0] k);
        return mk_req(op, txn, shr, k[58], k[57:48], k[47:16], k[15:0]);
    endfunction

    // Fill the table with fresh keys past capacity, then release every holder
    task automatic fill_and_drain();
        int e;
        for (int i = 0; i < NUM_ENTRIES + 3; i++)
            send_req(mk_req(2'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0,
                            1'b1, 10'($urandom), $urandom, 16'($urandom)));
        forever begin
            e = -1;
            for (int f = 0; f < NUM_ENTRIES; f++)
                if (sb.used[f]) begin e = f; break; end
            if (e < 0) break;
            send_req(req_for_key(REQ_UNLOCK, sb.holder_id[e][0],
                                 1'($urandom_range(0, 1)), sb.key_of[e]));
        end
    endtask

    initial begin
        logic [KEY_W-1:0] key_pool[8];
        logic [7:0]       txn_pool[10];
        lock_request_t    r;
        int               pick;

        i_rst_n = 1'b0;
        quiet = 1'b0;
        ready_gap = 0;
        idle_cycles = 0;
        sent = 0;
        rsp_ch.ready = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_SHARED;
        req_ch.has_txn = 1'b0;
        req_ch.txn_id = '0;
        req_ch.txn_shrinking = 1'b0;
        req_ch.is_record = 1'b0;
        req_ch.table_id = '0;
        req_ch.record_page = '0;
        req_ch.record_slot = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: no transaction, grants, upgrade, conflicts, unlock variants
        r = mk_req(REQ_EXCLUSIVE, 8'd3, 1'b1, 1'b1, 10'h3ff, '1, '1);
        r.has_txn = 1'b0;
        send_req(r);
        send_req(mk_req(REQ_SHARED, 8'd0, 1'b0, 1'b0, 10'd0, '0, '0));
        send_req(mk_req(REQ_SHARED, 8'd0, 1'b0, 1'b0, 10'd0, '0, '0));
        send_req(mk_req(REQ_SHARED, 8'd255, 1'b0, 1'b0, 10'd0, '0, '0));
        send_req(mk_req(REQ_EXCLUSIVE, 8'd0, 1'b0, 1'b0, 10'd0, '0, '0));
        send_req(mk_req(REQ_UNLOCK, 8'd255, 1'b0, 1'b0, 10'd0, '0, '0));
        send_req(mk_req(REQ_EXCLUSIVE, 8'd0, 1'b0, 1'b0, 10'd0, '0, '0));
        send_req(mk_req(REQ_SHARED, 8'd0, 1'b0, 1'b0, 10'd0, '0, '0));
        send_req(mk_req(REQ_SHARED, 8'd7, 1'b0, 1'b0, 10'd0, '0, '0));
        send_req(mk_req(REQ_EXCLUSIVE, 8'd7, 1'b1, 1'b0, 10'd0, '0, '0));
        // table lock with page and slot set maps to the same table key
        send_req(mk_req(REQ_EXCLUSIVE, 8'd0, 1'b0, 1'b0, 10'd0, '1, '1));
        send_req(mk_req(REQ_UNLOCK_ALT, 8'd0, 1'b1, 1'b0, 10'd0, '0, '0));
        send_req(mk_req(REQ_UNLOCK, 8'd0, 1'b0, 1'b0, 10'd0, '0, '0));
        send_req(mk_req(REQ_EXCLUSIVE, 8'd1, 1'b0, 1'b1, 10'h3ff, '1, '1));
        send_req(mk_req(REQ_UNLOCK, 8'd2, 1'b0, 1'b1, 10'h3ff, '1, '1));
        send_req(mk_req(REQ_UNLOCK, 8'd1, 1'b1, 1'b1, 10'h3ff, '1, '1));
        // overflow one holder list
        for (int t = 0; t <= NUM_HOLDERS; t++)
            send_req(mk_req(REQ_SHARED, 8'(t + 16), 1'b0, 1'b1, 10'd5, 32'd9, 16'd1));

        // Hold the sender until the block has answered everything
        req_ch.valid = 1'b0;
        wait (sb.owed_results.size() == 0);
        @(negedge i_clk);

        // Random: small pools of keys and transactions so requests collide
        while (sent < RANDOM_ITEMS + 25) begin
            if (sent % 300 < 2 || sent < 30) begin
                foreach (key_pool[i])
                    key_pool[i] = {1'($urandom), 10'($urandom), 32'($urandom), 16'($urandom)};
                foreach (txn_pool[i]) txn_pool[i] = 8'($urandom_range(0, 255));
                txn_pool[0] = 8'd0;
                txn_pool[1] = 8'd255;
            end
            quiet = (sent >= RANDOM_ITEMS + 25 - QUIET_TAIL);
            pick = $urandom_range(0, 99);
            if (pick == 0 && sent < RANDOM_ITEMS - 300) begin
                fill_and_drain();
            end else if (pick < 6) begin
                r = mk_req(2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                           10'($urandom), $urandom, 16'($urandom));
                r.has_txn = 1'($urandom_range(0, 1));
                send_req(r);
            end else begin
                r = req_for_key(2'($urandom_range(0, 3)),
                                txn_pool[$urandom_range(0, 9)],
                                ($urandom_range(0, 6) == 0),
                                key_pool[$urandom_range(0, 7)]);
                if (!r.is_record) begin
                    r.record_page = $urandom;
                    r.record_slot = 16'($urandom);
                end
                send_req(r);
            end
        end
        req_ch.valid = 1'b0;

        wait (sb.owed_results.size() == 0);
        repeat (400) @(posedge i_clk);

        $display("ran %0d requests, checked %0d results", sent, sb.checked);
        $display("ok %0d, shrink abort %0d, deadlock abort %0d, not found %0d, full %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3], sb.status_seen[4]);
        if (sb.errors == 0 && sb.owed_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/nwlt_pkg.sv
design/nwlt_if.sv
design/no_wait_lock_table_top.sv
tb/no_wait_lock_table_top_test.sv
